[rtl/core/cdtp_pkg.sv]
// Shared types and constants for the card device tuple parser.
// No dependencies; imported by the decoder, the top level and the checker.
`default_nettype none

package cdtp_pkg;

    localparam int unsigned POS_W  = 9;
    localparam int unsigned POS_MAX = 511;

    localparam logic CFG_DEVICE_CODE     = 1'b0;
    localparam logic CFG_DEVICE_CODE_ALT = 1'b1;

    localparam logic [7:0] DEVICE_CODE_RESET     = 8'd1;
    localparam logic [7:0] DEVICE_CODE_ALT_RESET = 8'd23;

    localparam logic [3:0] TYPE_IO       = 4'd13;
    localparam logic [3:0] TYPE_MAX_MEM  = 4'd7;
    localparam logic [31:0] SIZE_UNIT    = 32'd512;
    localparam logic [28:0] SIZE_IO_NONE = 29'd1;
    localparam logic [7:0] EXT_FLAG      = 8'h80;

    localparam logic [2:0] SPD_NONE = 3'd0;
    localparam logic [2:0] SPD_250  = 3'd1;
    localparam logic [2:0] SPD_200  = 3'd2;
    localparam logic [2:0] SPD_150  = 3'd3;
    localparam logic [2:0] SPD_100  = 3'd4;
    localparam logic [2:0] SPD_EXT  = 3'd7;

    typedef enum logic [2:0] {
        PH_CODE = 3'd0,
        PH_LINK = 3'd1,
        PH_ID   = 3'd2,
        PH_EXT  = 3'd3,
        PH_SKIP = 3'd4,
        PH_SIZE = 3'd5,
        PH_DONE = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [POS_W-1:0] pos;
        logic [7:0]       link;
        logic [3:0]       htype;
        logic [31:0]      speed;
        logic [28:0]      size;
        logic             rejected;
    } parse_state_t;

    typedef struct packed {
        logic        valid_res;
        logic [3:0]  device_type;
        logic [31:0] speed_ns;
        logic [28:0] size_bytes;
    } result_t;

    function automatic logic [31:0] mant_base(input logic [3:0] m);
        logic [31:0] v;
        case (m)
            4'd0:    v = 32'hFFFF_FFFB;
            4'd1:    v = 32'd10;
            4'd2:    v = 32'd12;
            4'd3:    v = 32'd13;
            4'd4:    v = 32'd15;
            4'd5:    v = 32'd20;
            4'd6:    v = 32'd25;
            4'd7:    v = 32'd30;
            4'd8:    v = 32'd35;
            4'd9:    v = 32'd40;
            4'd10:   v = 32'd45;
            4'd11:   v = 32'd50;
            4'd12:   v = 32'd55;
            4'd13:   v = 32'd60;
            4'd14:   v = 32'd65;
            default: v = 32'd70;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pow10_scale(input logic [2:0] e);
        logic [31:0] v;
        case (e)
            3'd2:    v = 32'd10;
            3'd3:    v = 32'd100;
            3'd4:    v = 32'd1000;
            3'd5:    v = 32'd10000;
            3'd6:    v = 32'd100000;
            3'd7:    v = 32'd1000000;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cdtp_in_stage.sv]
// Input register stage with stall generation for the tuple parser.
// Depends on nothing beyond the clock and reset.
`default_nettype none

module cdtp_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] tuple_byte,
    input  wire logic       last_byte,
    input  wire logic       advance,
    output logic            vld,
    output logic [7:0]      byte_q,
    output logic            last_q
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       take;

    assign in_stall = vld_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= tuple_byte;
            last_reg <= last_byte;
        end
    end

    assign vld    = vld_reg;
    assign byte_q = byte_reg;
    assign last_q = last_reg;

endmodule

`default_nettype wire

[rtl/core/cdtp_decode.sv]
// Combinational byte decoder: next parse state and the result of a finished tuple.
// Depends on cdtp_pkg for the state and result types and the speed tables.
`default_nettype none

module cdtp_decode
    import cdtp_pkg::*;
(
    input  wire parse_state_t cur,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_in,
    input  wire logic [7:0]  code_a,
    input  wire logic [7:0]  code_b,
    output parse_state_t     nxt,
    output result_t          res
);

    function automatic logic [31:0] ext_speed(input logic [7:0] b);
        logic [31:0] v;
        logic [31:0] h;
        v = mant_base(b[6:3]);
        h = v >> 1;
        if (b[2:0] == 3'd0)
        begin
            v = (h == 32'd0) ? 32'd1 : h;
        end
        else
        begin
            v = v * pow10_scale(b[2:0]);
        end
        return v;
    endfunction

    function automatic logic [28:0] size_calc(input logic [7:0] b);
        logic [31:0] shifted;
        logic [31:0] prod;
        shifted = SIZE_UNIT << {b[2:0], 1'b0};
        prod    = shifted * {26'd0, {1'b0, b[7:3]} + 6'd1};
        return prod[28:0];
    endfunction

    function automatic parse_state_t take_byte(input parse_state_t s, input logic [7:0] b);
        parse_state_t t;
        logic         in_link;
        t       = s;
        in_link = {1'b0, s.link} >= s.pos;
        case (s.phase)
            PH_CODE:
            begin
                if (b == code_a || b == code_b)
                begin
                    t.phase = PH_LINK;
                end
                else
                begin
                    t.rejected = 1'b1;
                    t.phase    = PH_DONE;
                end
            end
            PH_LINK:
            begin
                t.link = b;
                if (b == 8'd0)
                begin
                    t.rejected = 1'b1;
                    t.phase    = PH_DONE;
                end
                else
                begin
                    t.phase = PH_ID;
                end
            end
            PH_ID:
            begin
                t.htype = b[7:4];
                if (b[7:4] > TYPE_MAX_MEM && b[7:4] != TYPE_IO)
                begin
                    t.rejected = 1'b1;
                    t.phase    = PH_DONE;
                end
                else if (in_link)
                begin
                    case (b[2:0])
                        SPD_NONE: t.phase = PH_SIZE;
                        SPD_250:
                        begin
                            t.speed = 32'd250;
                            t.phase = PH_SIZE;
                        end
                        SPD_200:
                        begin
                            t.speed = 32'd200;
                            t.phase = PH_SIZE;
                        end
                        SPD_150:
                        begin
                            t.speed = 32'd150;
                            t.phase = PH_SIZE;
                        end
                        SPD_100:
                        begin
                            t.speed = 32'd100;
                            t.phase = PH_SIZE;
                        end
                        SPD_EXT:  t.phase = PH_EXT;
                        default:
                        begin
                            t.rejected = 1'b1;
                            t.phase    = PH_DONE;
                        end
                    endcase
                end
                else
                begin
                    t.phase = PH_SIZE;
                end
            end
            PH_EXT:
            begin
                t.speed = ext_speed(b);
                t.phase = (in_link && (b & EXT_FLAG) != 8'd0) ? PH_SKIP : PH_SIZE;
            end
            PH_SKIP:
            begin
                if (!(in_link && (b & EXT_FLAG) != 8'd0))
                begin
                    t.phase = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (in_link)
                begin
                    t.size = size_calc(b);
                end
                else if (s.htype == TYPE_IO)
                begin
                    t.size = SIZE_IO_NONE;
                end
                t.phase = PH_DONE;
            end
            default:
            begin
            end
        endcase
        if (s.pos != POS_W'(POS_MAX))
        begin
            t.pos = s.pos + POS_W'(1);
        end
        return t;
    endfunction

    parse_state_t    st1;
    parse_state_t    fin;
    logic [POS_W:0]  size_pos;
    logic            size_in_link;
    logic [3:0]      size_type;

    // Missing bytes read as zero, so the tail of the tuple is resolved in closed form.
    always_comb
    begin
        st1 = take_byte(cur, byte_in);
        fin = st1;

        if (st1.phase == PH_SIZE)
        begin
            size_pos = {1'b0, st1.pos};
        end
        else
        begin
            size_pos = {1'b0, st1.pos} + (POS_W+1)'(1);
        end
        size_in_link = {2'b00, st1.link} >= size_pos;
        size_type    = (st1.phase == PH_ID) ? 4'd0 : st1.htype;

        case (st1.phase)
            PH_CODE, PH_LINK:
            begin
                fin.rejected = 1'b1;
            end
            PH_ID, PH_EXT, PH_SKIP, PH_SIZE:
            begin
                fin.htype = size_type;
                if (st1.phase == PH_EXT)
                begin
                    fin.speed = ext_speed(8'd0);
                end
                if (size_in_link)
                begin
                    fin.size = size_calc(8'd0);
                end
                else if (size_type == TYPE_IO)
                begin
                    fin.size = SIZE_IO_NONE;
                end
            end
            default:
            begin
            end
        endcase

        res.valid_res   = !fin.rejected;
        res.device_type = fin.htype;
        res.speed_ns    = fin.rejected ? 32'd0 : fin.speed;
        res.size_bytes  = fin.rejected ? 29'd0 : fin.size;

        if (last_in)
        begin
            nxt = '0;
            nxt.phase = PH_CODE;
        end
        else
        begin
            nxt = st1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/card_device_tuple_parser_unit.sv]
// Top level of the card device tuple parser: configuration, parse state and result register.
// Depends on cdtp_pkg, cdtp_in_stage and cdtp_decode.
//
//  Channel   Direction  Handshake          Payload
//  input     in         in_valid/in_stall  tuple_byte, last_byte
//  result    out        out_valid/out_stall valid_res, device_type, speed_ns, size_bytes
//  config    in         cfg_we             cfg_index, cfg_data
//
// Bytes are taken one per cycle unless stalled; results register from the staged last byte.
// Unless stalled, one registered byte per cycle is decoded against the parse state register.
// Reset returns the codes to 1 and 23 and the parser to waiting for a tuple code.
// A stalled result holds; the input stage keeps taking bytes until a last byte waits behind it.
`default_nettype none

module card_device_tuple_parser_unit
    import cdtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  tuple_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             valid_res,
    output logic [3:0]       device_type,
    output logic [31:0]      speed_ns,
    output logic [28:0]      size_bytes
);

    logic [7:0]   code_a_reg;
    logic [7:0]   code_b_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_reg;
    result_t      res_next;
    logic         out_vld_reg;
    logic         out_vld_next;

    logic         stg_vld;
    logic [7:0]   stg_byte;
    logic         stg_last;
    logic         advance;

    assign advance = stg_vld && (!stg_last || !out_vld_reg || !out_stall);

    cdtp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tuple_byte (tuple_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .vld        (stg_vld),
        .byte_q     (stg_byte),
        .last_q     (stg_last)
    );

    cdtp_decode u_decode
    (
        .cur     (state_reg),
        .byte_in (stg_byte),
        .last_in (stg_last),
        .code_a  (code_a_reg),
        .code_b  (code_b_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_a_reg <= DEVICE_CODE_RESET;
            code_b_reg <= DEVICE_CODE_ALT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_CODE:     code_a_reg <= cfg_data;
                CFG_DEVICE_CODE_ALT: code_b_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The all-zero state is the wait for a tuple code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        if (advance && stg_last)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_vld_next = out_vld_reg;
        end
        else
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stg_last)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign valid_res   = res_reg.valid_res;
    assign device_type = res_reg.device_type;
    assign speed_ns    = res_reg.speed_ns;
    assign size_bytes  = res_reg.size_bytes;

endmodule

`default_nettype wire

[rtl/core/cdtp_checker.sv]
// Port-level checks for the card device tuple parser, bound to the top level.
// Depends on card_device_tuple_parser_unit and cdtp_pkg.
`default_nettype none

module cdtp_checker
    import cdtp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        last_byte,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        valid_res,
    input wire logic [3:0]  device_type,
    input wire logic [31:0] speed_ns,
    input wire logic [28:0] size_bytes
);

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> speed_ns == 32'd0 && size_bytes == 29'd0)
        else $error("rejected item carries speed or size");

    a_type_legal : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> device_type <= TYPE_MAX_MEM || device_type == TYPE_IO)
        else $error("accepted item has an illegal device type");

    a_io_size : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res && device_type == TYPE_IO |-> size_bytes != 29'd0)
        else $error("accepted I/O device item has zero size");

    a_result_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte, 2))
        else $error("result item without a preceding last byte");

endmodule

bind card_device_tuple_parser_unit cdtp_checker u_cdtp_checker (.*);

`default_nettype wire
